@@ design/yuv422_to_rgb888_converter_defines.svh @@
// ----------------------------------------------------------------------------
// yuv422_to_rgb888_converter_defines
// Assertion macros shared by the converter modules.
// ----------------------------------------------------------------------------
`ifndef YUV422_TO_RGB888_CONVERTER_DEFINES_SVH
`define YUV422_TO_RGB888_CONVERTER_DEFINES_SVH

`ifndef ASSERT_OFF
// property that must hold at every edge outside reset
`define YRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent this edge implies consequent at the next edge
`define YRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define YRC_ASSERT(lbl, prop, msg)
`define YRC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/yrc_pkg.sv @@
// ----------------------------------------------------------------------------
// yrc_pkg
// Types, coefficients and helpers for the YUV 4:2:2 to RGB888 converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package yrc_pkg;

  // pixel format register codes; code 3 unpacks like NV16
  typedef enum logic [1:0] {
    FMT_UYVY = 2'd0,
    FMT_YUYV = 2'd1,
    FMT_NV16 = 2'd2
  } pix_fmt_t;

  // Q16 conversion coefficients
  localparam logic signed [17:0] KRV = 18'sd89831;
  localparam logic signed [17:0] KGV = 18'sd45744;
  localparam logic signed [17:0] KGU = 18'sd22127;
  localparam logic signed [17:0] KBU = 18'sd113538;

  localparam int unsigned PIX_W = 8;

  typedef logic signed [25:0] prod_t;   // coefficient * chroma offset
  typedef logic signed [26:0] sum_t;    // luma plus chroma terms

  // per-pixel sideband
  typedef struct packed {
    logic second;      // second pixel of the pair
    logic frame_end;   // second pixel of the frame's last pair
  } pix_tag_t;

  // one pixel's conversion inputs
  typedef struct packed {
    logic [PIX_W-1:0] y;
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] v;
    pix_tag_t         tag;
  } pix_in_t;

  // chroma minus 128 as a signed byte: flip the MSB
  function automatic logic signed [7:0] chroma_ofs(input logic [7:0] c);
    chroma_ofs = {~c[7], c[6:0]};
  endfunction

  // truncate Q16 sum toward zero and clamp to 0..255
  function automatic logic [7:0] clamp_u8(input sum_t s);
    logic [7:0] res;
    if (s[26]) begin
      res = 8'd0;
    end else if (|s[25:24]) begin
      res = 8'd255;
    end else begin
      res = s[23:16];
    end
    clamp_u8 = res;
  endfunction

endpackage

@@ design/yrc_pixel_pipe.sv @@
// ----------------------------------------------------------------------------
// yrc_pixel_pipe
// Three-stage pixel converter: multiply, sum, clamp into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "yuv422_to_rgb888_converter_defines.svh"

module yrc_pixel_pipe (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pix_valid,
  output logic              pix_ready,
  input  yrc_pkg::pix_in_t  pix_in,
  output logic              rgb_valid,
  input  logic              rgb_ready,
  output logic [23:0]       rgb_out,     // red, green, blue from bit 0 up
  output yrc_pkg::pix_tag_t rgb_tag
);
  import yrc_pkg::*;

  // stage enables: a stage loads when empty or draining downstream
  logic en1, en2, en3;

  logic       v1_r, v2_r, v3_r;
  logic       v1_nxt, v2_nxt, v3_nxt;

  // stage 1: products
  logic [7:0] y1_r;
  prod_t      prv_r, pgv_r, pgu_r, pbu_r;
  pix_tag_t   tag1_r;

  // stage 2: sums
  sum_t       sr_r, sg_r, sb_r;
  pix_tag_t   tag2_r;

  // stage 3: clamped pixel
  logic [23:0] rgb_r;
  pix_tag_t    tag3_r;

  logic signed [7:0] du, dv;
  sum_t              yq;

  assign en3 = !v3_r || rgb_ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign pix_ready = en1;

  assign du = chroma_ofs(pix_in.u);
  assign dv = chroma_ofs(pix_in.v);
  assign yq = sum_t'({3'b000, y1_r, 16'h0000});

  // valid bits
  always_comb begin
    v1_nxt = en1 ? pix_valid : v1_r;
    v2_nxt = en2 ? v1_r : v2_r;
    v3_nxt = en3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // stage 1: chroma products
  always_ff @(posedge clk) begin
    if (en1) begin
      y1_r   <= pix_in.y;
      prv_r  <= prod_t'(KRV) * prod_t'(dv);
      pgv_r  <= prod_t'(KGV) * prod_t'(dv);
      pgu_r  <= prod_t'(KGU) * prod_t'(du);
      pbu_r  <= prod_t'(KBU) * prod_t'(du);
      tag1_r <= pix_in.tag;
    end
  end

  // stage 2: Q16 sums
  always_ff @(posedge clk) begin
    if (en2) begin
      sr_r   <= yq + sum_t'(prv_r);
      sg_r   <= yq - sum_t'(pgv_r) - sum_t'(pgu_r);
      sb_r   <= yq + sum_t'(pbu_r);
      tag2_r <= tag1_r;
    end
  end

  // stage 3: truncate and clamp
  always_ff @(posedge clk) begin
    if (en3) begin
      rgb_r  <= {clamp_u8(sb_r), clamp_u8(sg_r), clamp_u8(sr_r)};
      tag3_r <= tag2_r;
    end
  end

  assign rgb_valid = v3_r;
  assign rgb_out   = rgb_r;
  assign rgb_tag   = tag3_r;

  // a stalled output keeps stage 2 full if it was full
  `YRC_ASSERT_NEXT(a_stall_keeps_s2, v3_r && !rgb_ready && v2_r, v2_r,
                   "stage 2 lost a pixel during an output stall")
  // frame end only ever rides on a second pixel
  `YRC_ASSERT(a_tag_s2, !v2_r || !tag2_r.frame_end || tag2_r.second,
              "frame end on a first pixel in stage 2")
  // valid bits advance one stage when the stage below can take them
  `YRC_ASSERT_NEXT(a_s1_to_s2, v1_r && en2, v2_r,
                   "stage 1 pixel did not reach stage 2")

endmodule

@@ design/yuv422_to_rgb888_converter.sv @@
// ----------------------------------------------------------------------------
// yuv422_to_rgb888_converter
// Unpacks one 4:2:2 pixel pair per input beat and emits two RGB888 pixels.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                      | tuser          | tlast
//  in_     | in  | pixel_word[31:0]           | -              | last_in_frame
//  out_    | out | red[7:0] green blue [23:0] | second_of_pair | frame_end
//  cfg_    | in  | pixel_format[1:0]          | -              | -
//
//  A new pair is taken while the last pair's second pixel issues, paced by the
//  single output channel that carries one pixel per beat; out_tready stalls hold it.
//  A pair register splits the word into two pixels for a 3-stage pipeline.
//  rst_n (synchronous) clears valid bits and sets the format to UYVY.
//  Stalls on out_tready back up stage by stage; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "yuv422_to_rgb888_converter_defines.svh"

module yuv422_to_rgb888_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,   // pixel_format
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // pixel_word
  input  logic        in_tlast,      // last_in_frame
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,     // red, green, blue
  output logic        out_tuser,     // second_of_pair
  output logic        out_tlast      // frame_end
);
  import yrc_pkg::*;

  pix_fmt_t   fmt_r, fmt_nxt;

  // pair register
  logic       s0_valid_r, s0_valid_nxt;
  logic       phase_r, phase_nxt;
  logic [7:0] y0_r, y1_r, u_r, v_r;
  logic       last_r;
  logic [7:0] y0_nxt, y1_nxt, u_nxt, v_nxt;

  logic       accept, issue, pipe_ready;
  pix_in_t    pix;
  logic       rgb_valid;
  pix_tag_t   rgb_tag;

  // format register
  always_comb begin
    fmt_nxt = cfg_wr_en ? pix_fmt_t'(cfg_wr_data) : fmt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_UYVY;
    end else begin
      fmt_r <= fmt_nxt;
    end
  end

  // byte unpack by format; code 3 falls to NV16 layout
  always_comb begin
    unique case (fmt_r)
      FMT_UYVY: begin
        y0_nxt = in_tdata[15:8];
        y1_nxt = in_tdata[31:24];
        u_nxt  = in_tdata[23:16];
        v_nxt  = in_tdata[7:0];
      end
      FMT_YUYV: begin
        y0_nxt = in_tdata[7:0];
        y1_nxt = in_tdata[23:16];
        u_nxt  = in_tdata[15:8];
        v_nxt  = in_tdata[31:24];
      end
      default: begin
        y0_nxt = in_tdata[7:0];
        y1_nxt = in_tdata[15:8];
        u_nxt  = in_tdata[31:24];
        v_nxt  = in_tdata[23:16];
      end
    endcase
  end

  // handshake: free when empty or when the second pixel leaves now
  assign issue     = s0_valid_r && pipe_ready;
  assign in_tready = !s0_valid_r || (phase_r && pipe_ready);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    s0_valid_nxt = s0_valid_r;
    phase_nxt    = phase_r;
    if (issue) begin
      phase_nxt = 1'b1;
      if (phase_r) begin
        s0_valid_nxt = 1'b0;
      end
    end
    if (accept) begin
      s0_valid_nxt = 1'b1;
      phase_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      phase_r    <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
      phase_r    <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      y0_r   <= y0_nxt;
      y1_r   <= y1_nxt;
      u_r    <= u_nxt;
      v_r    <= v_nxt;
      last_r <= in_tlast;
    end
  end

  // pick the pixel for this phase
  always_comb begin
    pix.y             = phase_r ? y1_r : y0_r;
    pix.u             = u_r;
    pix.v             = v_r;
    pix.tag.second    = phase_r;
    pix.tag.frame_end = phase_r && last_r;
  end

  yrc_pixel_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (s0_valid_r),
    .pix_ready (pipe_ready),
    .pix_in    (pix),
    .rgb_valid (rgb_valid),
    .rgb_ready (out_tready),
    .rgb_out   (out_tdata),
    .rgb_tag   (rgb_tag)
  );

  assign out_tvalid = rgb_valid;
  assign out_tuser  = rgb_tag.second;
  assign out_tlast  = rgb_tag.frame_end;

  // a new pair always starts on its first pixel
  `YRC_ASSERT_NEXT(a_accept_first, accept, s0_valid_r && !phase_r,
                   "accepted pair not held on first pixel")
  // after the first pixel leaves, the second is still pending
  `YRC_ASSERT_NEXT(a_first_then_second, issue && !phase_r, s0_valid_r && phase_r,
                   "second pixel of pair lost")
  // no new pair while the first pixel is still waiting
  `YRC_ASSERT(a_no_overwrite, !(s0_valid_r && !phase_r) || !in_tready,
              "pair register ready with first pixel pending")
  // frame end only on a second pixel
  `YRC_ASSERT(a_tlast_second, !out_tvalid || !out_tlast || out_tuser,
              "frame end on a first pixel")

endmodule
